// ===== sv/ncrf_pkg.sv =====
// Package of the network coding relay framer: constants, codes and shared types.
package ncrf_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_PACKET_DEF = 256;

  localparam int ID_REPEAT   = 3;
  localparam int NUM_REPEAT  = 3;
  localparam int SESSION_LEN = 6;
  localparam int TRAILER_LEN = 6;
  localparam int TRAILER_MIN = 5;
  localparam int CONFIRM_LEN = 6;
  localparam int GUARD_MIN   = 6;
  localparam int PACKET_MIN  = 7;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_MAX  = 8'hFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SESSION_MODE  = 3'd0,
    REG_GUARD_ENABLE  = 3'd1,
    REG_GUARD_LENGTH  = 3'd2,
    REG_NODE_A_ID     = 3'd3,
    REG_NODE_B_ID     = 3'd4,
    REG_RELAY_ID      = 3'd5,
    REG_PACKET_LENGTH = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RX_IDLE    = 3'd0,
    RX_ID      = 3'd1,
    RX_NUMBER  = 3'd2,
    RX_SESSION = 3'd3,
    RX_DATA    = 3'd4,
    RX_END     = 3'd5
  } rx_phase_t;

  typedef enum logic [3:0] {
    TX_IDLE    = 4'd0,
    TX_CONFIRM = 4'd1,
    TX_SESSION = 4'd2,
    TX_NODE_ID = 4'd3,
    TX_NUMBER  = 4'd4,
    TX_DATA    = 4'd5,
    TX_GUARD   = 4'd6,
    TX_CHECK   = 4'd7,
    TX_SLEEP   = 4'd8
  } tx_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CMT_A = 3'd1,
    ST_CPY_A = 3'd2,
    ST_CMT_B = 3'd3,
    ST_CPY_B = 3'd4,
    ST_TX    = 3'd5,
    ST_RD    = 3'd6
  } ctl_state_t;

  // Control inputs of one receiver lane.
  typedef struct packed {
    logic       session_mode;
    logic       req_own;
    logic       confirmed;
    logic [7:0] id;
    logic [7:0] expected;
  } rx_ctl_t;

  // Events a receiver lane reports for one step.
  typedef struct packed {
    logic       set_req;
    logic       commit;
    logic [7:0] num;
  } rx_evt_t;

endpackage

// ===== sv/ncrf_in_if.sv =====
// Input channel interface: one byte from each end node per transfer.
interface ncrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_a;
  logic [7:0] byte_b;

  modport source (output valid, output byte_a, output byte_b, input ready);
  modport sink (input valid, input byte_a, input byte_b, output ready);
endinterface

// ===== sv/ncrf_out_if.sv =====
// Result channel interface: one downlink byte per transfer.
interface ncrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;

  modport source (output valid, output tx_byte, input ready);
  modport sink (input valid, input tx_byte, output ready);
endinterface

// ===== sv/ncrf_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
interface ncrf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ncrf_pkg::CFG_IDX_W-1:0]  index;
  logic [ncrf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/network_coding_relay_framer.sv =====
// Top level of the two-way network coding relay framer.
//
//  channel  direction  transfer payload
//  in_ch    sink       byte_a, byte_b   one uplink byte from each end node
//  out_ch   source     tx_byte          one downlink byte
//  cfg_ch   sink       index, data      one configuration register write
//
// An item passes through the steps accept, commit A, commit B, store read and transmit step.
// A packet committed to a fresh slot adds, per side, the byte copy from that
// lane's staging RAM into its packet store, one byte a cycle.
// Reset is synchronous and active low; the packet stores need no clearing pass.
// A full output register holds the transmit step until the result is taken.
// Configuration writes are always taken and are registered directly.
module network_coding_relay_framer #(
  parameter int SLOT_COUNT = ncrf_pkg::SLOT_COUNT_DEF,
  parameter int MAX_PACKET = ncrf_pkg::MAX_PACKET_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ncrf_in_if.sink      in_ch,
  ncrf_out_if.source   out_ch,
  ncrf_cfg_if.sink     cfg_ch
);

  localparam int KW       = $clog2(MAX_PACKET);
  localparam int LW       = $clog2(MAX_PACKET + 1);
  localparam int SW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ST_DEPTH = SLOT_COUNT * (1 << KW);
  localparam int ST_AW    = $clog2(ST_DEPTH);

  // Configuration registers.
  logic       session_mode_r;
  logic       guard_enable_r;
  logic [7:0] guard_length_r;
  logic [7:0] node_a_id_r;
  logic [7:0] node_b_id_r;
  logic [7:0] relay_id_r;
  logic [8:0] packet_length_r;

  logic [LW-1:0] eff_len;
  logic [7:0]    eff_guard;

  // Sequencer and shared relay state.
  ncrf_pkg::ctl_state_t state_r, state_nxt;
  logic req_a_r, req_a_nxt, req_b_r, req_b_nxt;
  logic confirmed_r, confirmed_nxt, full_r, full_nxt, outf_r, outf_nxt;
  logic [7:0] exp_r, exp_nxt;
  logic [SLOT_COUNT-1:0] own_a_r, own_a_nxt, own_b_r, own_b_nxt;
  logic [SLOT_COUNT-1:0] xored_r, xored_nxt, pend_v_r, pend_v_nxt;
  logic [SW-1:0] pend_slot_r [SLOT_COUNT];
  logic [SW-1:0] pend_slot_nxt [SLOT_COUNT];

  ncrf_pkg::tx_phase_t tx_phase_r, tx_phase_nxt;
  logic [LW-1:0] tx_conf_r, tx_conf_nxt, tx_data_r, tx_data_nxt;
  logic [1:0]    tx_rep_r, tx_rep_nxt;
  logic [7:0]    tx_guard_r, tx_guard_nxt;
  logic [SW-1:0] tx_slot_r, tx_slot_nxt;

  ncrf_pkg::rx_evt_t evt_a, evt_b, evt_a_r, evt_a_nxt, evt_b_r, evt_b_nxt;
  ncrf_pkg::rx_ctl_t ctl_a, ctl_b;

  // Staging-to-store copy engine.
  logic          cp_side_r, cp_side_nxt;
  logic [SW-1:0] cp_slot_r, cp_slot_nxt;
  logic [LW-1:0] cp_rk_r, cp_rk_nxt;
  logic          cp_wv_r, cp_wv_nxt;
  logic [KW-1:0] cp_wk_r, cp_wk_nxt;
  logic          cp_rd;
  logic          stg_re_a, stg_re_b;
  logic [7:0]    stg_rdata_a, stg_rdata_b, cp_wdata;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  logic in_acc, out_acc, cfg_acc;
  logic st_re;
  logic [ST_AW-1:0] st_raddr, st_waddr;
  logic [7:0] st_rdata_a, st_rdata_b;

  // Helpers of the merge stage.
  ncrf_pkg::rx_evt_t cm_evt;
  logic [SLOT_COUNT-1:0] cm_own, cm_oth;
  logic          cm_hit, cm_copy, cm_queue;
  logic [SW-1:0] cm_s;
  logic          q_found, fp_found, fp2_found;
  logic [SW-1:0] q_idx, fp_idx, fp2_idx;
  logic [SLOT_COUNT-1:0] pend_rest;
  logic          both_req, go, tx_emit, guard_done;
  logic [7:0]    tx_out;
  logic [LW-1:0] conf_t, data_t;
  logic [1:0]    rep_t;
  logic [7:0]    guard_t;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready    = (state_r == ncrf_pkg::ST_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.tx_byte = out_byte_r;

  // The length in use saturates into the supported packet range.
  always_comb begin
    if (packet_length_r < 9'(ncrf_pkg::PACKET_MIN)) begin
      eff_len = LW'(ncrf_pkg::PACKET_MIN);
    end else if (32'(packet_length_r) > MAX_PACKET) begin
      eff_len = LW'(MAX_PACKET);
    end else begin
      eff_len = LW'(packet_length_r);
    end
  end

  assign eff_guard = (guard_length_r < 8'(ncrf_pkg::GUARD_MIN)) ?
                     8'(ncrf_pkg::GUARD_MIN) : guard_length_r;
  assign both_req  = req_a_r && req_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_mode_r  <= 1'b0;
      guard_enable_r  <= 1'b1;
      guard_length_r  <= 8'd6;
      node_a_id_r     <= 8'd1;
      node_b_id_r     <= 8'd2;
      relay_id_r      <= 8'd3;
      packet_length_r <= 9'd64;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        ncrf_pkg::REG_SESSION_MODE:  session_mode_r  <= cfg_ch.data[0];
        ncrf_pkg::REG_GUARD_ENABLE:  guard_enable_r  <= cfg_ch.data[0];
        ncrf_pkg::REG_GUARD_LENGTH:  guard_length_r  <= cfg_ch.data[7:0];
        ncrf_pkg::REG_NODE_A_ID:     node_a_id_r     <= cfg_ch.data[7:0];
        ncrf_pkg::REG_NODE_B_ID:     node_b_id_r     <= cfg_ch.data[7:0];
        ncrf_pkg::REG_RELAY_ID:      relay_id_r      <= cfg_ch.data[7:0];
        ncrf_pkg::REG_PACKET_LENGTH: packet_length_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Two receiver lanes parse the A and B streams side by side.
  always_comb begin
    ctl_a.session_mode = session_mode_r;
    ctl_a.req_own      = req_a_r;
    ctl_a.confirmed    = confirmed_r;
    ctl_a.id           = node_a_id_r;
    ctl_a.expected     = exp_r;
    ctl_b.session_mode = session_mode_r;
    ctl_b.req_own      = req_b_r;
    ctl_b.confirmed    = confirmed_r;
    ctl_b.id           = node_b_id_r;
    ctl_b.expected     = exp_r;
  end

  ncrf_rx #(.MAX_PACKET(MAX_PACKET)) u_rx_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_acc),
    .byte_i   (in_ch.byte_a),
    .ctl      (ctl_a),
    .eff_len  (eff_len),
    .evt      (evt_a),
    .cp_re    (stg_re_a),
    .cp_raddr (cp_rk_r[KW-1:0]),
    .cp_rdata (stg_rdata_a)
  );

  ncrf_rx #(.MAX_PACKET(MAX_PACKET)) u_rx_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_acc),
    .byte_i   (in_ch.byte_b),
    .ctl      (ctl_b),
    .eff_len  (eff_len),
    .evt      (evt_b),
    .cp_re    (stg_re_b),
    .cp_raddr (cp_rk_r[KW-1:0]),
    .cp_rdata (stg_rdata_b)
  );

  // Packet stores, one per end node. The coded packet is formed on the fly as
  // the XOR of both stores, since a coded slot never changes until the tables
  // are cleared.
  assign cp_wdata = cp_side_r ? stg_rdata_b : stg_rdata_a;
  assign st_waddr = ST_AW'({cp_slot_r, cp_wk_r});
  assign st_raddr = ST_AW'({pend_slot_r[tx_slot_r], tx_data_r[KW-1:0]});

  ncrf_ram #(.WIDTH(8), .DEPTH(ST_DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cp_wv_r && !cp_side_r),
    .waddr (st_waddr),
    .wdata (cp_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata_a)
  );

  ncrf_ram #(.WIDTH(8), .DEPTH(ST_DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cp_wv_r && cp_side_r),
    .waddr (st_waddr),
    .wdata (cp_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata_b)
  );

  // Priority searches over the pending queue.
  always_comb begin
    pend_rest = pend_v_r;
    pend_rest[tx_slot_r] = 1'b0;
    q_found   = 1'b0;
    q_idx     = '0;
    fp_found  = 1'b0;
    fp_idx    = '0;
    fp2_found = 1'b0;
    fp2_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!pend_v_r[i]) begin
        q_found = 1'b1;
        q_idx   = SW'(i);
      end
      if (pend_v_r[i]) begin
        fp_found = 1'b1;
        fp_idx   = SW'(i);
      end
      if (pend_rest[i]) begin
        fp2_found = 1'b1;
        fp2_idx   = SW'(i);
      end
    end
  end

  // Commit of one lane's packet: claim the slot, mark it coded when the other
  // end already holds the same number, and queue the coded packet.
  always_comb begin
    cm_evt = (state_r == ncrf_pkg::ST_CMT_B) ? evt_b_r : evt_a_r;
    cm_own = (state_r == ncrf_pkg::ST_CMT_B) ? own_b_r : own_a_r;
    cm_oth = (state_r == ncrf_pkg::ST_CMT_B) ? own_a_r : own_b_r;
    cm_hit = cm_evt.commit && (cm_evt.num != ncrf_pkg::BYTE_ZERO) &&
             ({1'b0, cm_evt.num} <= 9'(SLOT_COUNT));
    cm_s   = SW'(cm_evt.num - ncrf_pkg::BYTE_ONE);
    cm_copy  = cm_hit && !cm_own[cm_s];
    cm_queue = cm_hit && (cm_own[cm_s] ? xored_r[cm_s] : cm_oth[cm_s]);
  end

  always_comb begin
    state_nxt     = state_r;
    req_a_nxt     = req_a_r;
    req_b_nxt     = req_b_r;
    confirmed_nxt = confirmed_r;
    full_nxt      = full_r;
    outf_nxt      = outf_r;
    exp_nxt       = exp_r;
    own_a_nxt     = own_a_r;
    own_b_nxt     = own_b_r;
    xored_nxt     = xored_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    tx_phase_nxt  = tx_phase_r;
    tx_conf_nxt   = tx_conf_r;
    tx_data_nxt   = tx_data_r;
    tx_rep_nxt    = tx_rep_r;
    tx_guard_nxt  = tx_guard_r;
    tx_slot_nxt   = tx_slot_r;
    evt_a_nxt     = evt_a_r;
    evt_b_nxt     = evt_b_r;
    cp_side_nxt   = cp_side_r;
    cp_slot_nxt   = cp_slot_r;
    cp_rk_nxt     = cp_rk_r;
    cp_wv_nxt     = 1'b0;
    cp_wk_nxt     = cp_rk_r[KW-1:0];
    cp_rd         = 1'b0;
    stg_re_a      = 1'b0;
    stg_re_b      = 1'b0;
    st_re         = 1'b0;
    out_valid_nxt = out_valid_r && !out_acc;
    out_byte_nxt  = out_byte_r;
    go            = !out_valid_r || out_ch.ready;
    tx_emit       = 1'b0;
    tx_out        = ncrf_pkg::BYTE_ZERO;
    conf_t        = LW'(tx_conf_r + 1'b1);
    data_t        = LW'(tx_data_r + 1'b1);
    rep_t         = tx_rep_r + 2'd1;
    guard_t       = guard_enable_r ? tx_guard_r + 8'd1 : tx_guard_r;
    guard_done    = (guard_t >= eff_guard) || !guard_enable_r;

    unique case (state_r)
      ncrf_pkg::ST_IDLE: begin
        if (in_acc) begin
          evt_a_nxt = evt_a;
          evt_b_nxt = evt_b;
          if (evt_a.set_req) begin
            req_a_nxt = 1'b1;
          end
          if (evt_b.set_req) begin
            req_b_nxt = 1'b1;
          end
          state_nxt = ncrf_pkg::ST_CMT_A;
        end
      end
      ncrf_pkg::ST_CMT_A, ncrf_pkg::ST_CMT_B: begin
        if (cm_copy) begin
          if (state_r == ncrf_pkg::ST_CMT_B) begin
            own_b_nxt[cm_s] = 1'b1;
          end else begin
            own_a_nxt[cm_s] = 1'b1;
          end
          if (cm_oth[cm_s]) begin
            xored_nxt[cm_s] = 1'b1;
          end
        end
        if (cm_queue && q_found) begin
          pend_v_nxt[q_idx]    = 1'b1;
          pend_slot_nxt[q_idx] = cm_s;
        end
        cp_side_nxt = (state_r == ncrf_pkg::ST_CMT_B);
        cp_slot_nxt = cm_s;
        cp_rk_nxt   = '0;
        if (state_r == ncrf_pkg::ST_CMT_B) begin
          state_nxt = cm_copy ? ncrf_pkg::ST_CPY_B : ncrf_pkg::ST_TX;
        end else begin
          state_nxt = cm_copy ? ncrf_pkg::ST_CPY_A : ncrf_pkg::ST_CMT_B;
        end
      end
      ncrf_pkg::ST_CPY_A, ncrf_pkg::ST_CPY_B: begin
        // Each store write follows its staging read in the next cycle.
        cp_rd     = (cp_rk_r < eff_len);
        stg_re_a  = cp_rd && !cp_side_r;
        stg_re_b  = cp_rd && cp_side_r;
        cp_wv_nxt = cp_rd;
        if (cp_rd) begin
          cp_rk_nxt = LW'(cp_rk_r + 1'b1);
        end else begin
          state_nxt = (state_r == ncrf_pkg::ST_CPY_B) ? ncrf_pkg::ST_TX : ncrf_pkg::ST_CMT_B;
        end
      end
      ncrf_pkg::ST_TX: begin
        st_re     = 1'b1;
        state_nxt = ncrf_pkg::ST_RD;
      end
      ncrf_pkg::ST_RD: begin
        if (go) begin
          state_nxt = ncrf_pkg::ST_IDLE;
          unique case (tx_phase_r)
            ncrf_pkg::TX_IDLE: begin
              if (!session_mode_r) begin
                if (fp_found) begin
                  outf_nxt     = 1'b1;
                  tx_slot_nxt  = fp_idx;
                  tx_phase_nxt = ncrf_pkg::TX_NODE_ID;
                end
              end else if (both_req) begin
                tx_phase_nxt = ncrf_pkg::TX_CONFIRM;
              end
            end
            ncrf_pkg::TX_CONFIRM: begin
              tx_emit = 1'b1;
              tx_out  = (tx_conf_r < LW'(ncrf_pkg::ID_REPEAT)) ? relay_id_r
                                                               : ncrf_pkg::BYTE_ZERO;
              if (conf_t >= LW'(ncrf_pkg::CONFIRM_LEN)) begin
                tx_conf_nxt  = '0;
                tx_phase_nxt = ncrf_pkg::TX_SESSION;
              end else begin
                tx_conf_nxt = conf_t;
              end
            end
            ncrf_pkg::TX_SESSION: begin
              tx_emit = 1'b1;
              tx_out  = exp_r;
              if (conf_t >= LW'(eff_len - LW'(ncrf_pkg::CONFIRM_LEN))) begin
                confirmed_nxt = 1'b1;
                tx_conf_nxt   = '0;
                if (fp_found) begin
                  outf_nxt     = 1'b1;
                  tx_slot_nxt  = fp_idx;
                  tx_phase_nxt = ncrf_pkg::TX_NODE_ID;
                end else begin
                  tx_phase_nxt = ncrf_pkg::TX_CONFIRM;
                end
              end else begin
                tx_conf_nxt = conf_t;
              end
            end
            ncrf_pkg::TX_NODE_ID: begin
              tx_emit = 1'b1;
              tx_out  = relay_id_r;
              if (rep_t >= 2'(ncrf_pkg::ID_REPEAT)) begin
                tx_rep_nxt   = '0;
                tx_phase_nxt = ncrf_pkg::TX_NUMBER;
              end else begin
                tx_rep_nxt = rep_t;
              end
            end
            ncrf_pkg::TX_NUMBER: begin
              tx_emit = 1'b1;
              tx_out  = 8'(pend_slot_r[tx_slot_r]) + ncrf_pkg::BYTE_ONE;
              if (rep_t >= 2'(ncrf_pkg::NUM_REPEAT)) begin
                tx_rep_nxt   = '0;
                tx_phase_nxt = ncrf_pkg::TX_DATA;
              end else begin
                tx_rep_nxt = rep_t;
              end
            end
            ncrf_pkg::TX_DATA: begin
              tx_emit = 1'b1;
              tx_out  = st_rdata_a ^ st_rdata_b;
              if (data_t >= eff_len) begin
                tx_data_nxt  = '0;
                tx_phase_nxt = ncrf_pkg::TX_GUARD;
              end else begin
                tx_data_nxt = data_t;
              end
            end
            ncrf_pkg::TX_GUARD: begin
              tx_emit = guard_enable_r;
              tx_out  = ncrf_pkg::BYTE_ZERO;
              if (guard_done) begin
                tx_guard_nxt          = '0;
                pend_v_nxt[tx_slot_r] = 1'b0;
                if (fp2_found) begin
                  tx_slot_nxt  = fp2_idx;
                  tx_phase_nxt = ncrf_pkg::TX_NODE_ID;
                end else begin
                  tx_phase_nxt = ncrf_pkg::TX_CHECK;
                end
                // Every slot coded ends the run, or the session epoch.
                if (outf_r && (!session_mode_r || both_req) && (&xored_r)) begin
                  if (!session_mode_r) begin
                    tx_phase_nxt = ncrf_pkg::TX_SLEEP;
                  end else begin
                    req_a_nxt = 1'b0;
                    req_b_nxt = 1'b0;
                    outf_nxt  = 1'b0;
                    full_nxt  = 1'b1;
                    exp_nxt   = (exp_r == ncrf_pkg::BYTE_MAX) ? ncrf_pkg::BYTE_ONE
                                                              : exp_r + 8'd1;
                  end
                end
              end else begin
                tx_guard_nxt = guard_t;
              end
            end
            ncrf_pkg::TX_CHECK: begin
              if (full_r && both_req) begin
                confirmed_nxt = 1'b0;
                full_nxt      = 1'b0;
                tx_phase_nxt  = ncrf_pkg::TX_CONFIRM;
                own_a_nxt     = '0;
                own_b_nxt     = '0;
                xored_nxt     = '0;
                pend_v_nxt    = '0;
              end else if (fp_found) begin
                tx_slot_nxt  = fp_idx;
                tx_phase_nxt = ncrf_pkg::TX_NODE_ID;
              end
            end
            ncrf_pkg::TX_SLEEP: ;
            default: tx_phase_nxt = ncrf_pkg::TX_IDLE;
          endcase
          if (tx_emit) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = tx_out;
          end
        end
      end
      default: state_nxt = ncrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncrf_pkg::ST_IDLE;
      req_a_r     <= 1'b0;
      req_b_r     <= 1'b0;
      confirmed_r <= 1'b0;
      full_r      <= 1'b0;
      outf_r      <= 1'b0;
      exp_r       <= ncrf_pkg::BYTE_ONE;
      own_a_r     <= '0;
      own_b_r     <= '0;
      xored_r     <= '0;
      pend_v_r    <= '0;
      tx_phase_r  <= ncrf_pkg::TX_IDLE;
      tx_conf_r   <= '0;
      tx_data_r   <= '0;
      tx_rep_r    <= '0;
      tx_guard_r  <= '0;
      tx_slot_r   <= '0;
      evt_a_r     <= '0;
      evt_b_r     <= '0;
      cp_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_a_r     <= req_a_nxt;
      req_b_r     <= req_b_nxt;
      confirmed_r <= confirmed_nxt;
      full_r      <= full_nxt;
      outf_r      <= outf_nxt;
      exp_r       <= exp_nxt;
      own_a_r     <= own_a_nxt;
      own_b_r     <= own_b_nxt;
      xored_r     <= xored_nxt;
      pend_v_r    <= pend_v_nxt;
      tx_phase_r  <= tx_phase_nxt;
      tx_conf_r   <= tx_conf_nxt;
      tx_data_r   <= tx_data_nxt;
      tx_rep_r    <= tx_rep_nxt;
      tx_guard_r  <= tx_guard_nxt;
      tx_slot_r   <= tx_slot_nxt;
      evt_a_r     <= evt_a_nxt;
      evt_b_r     <= evt_b_nxt;
      cp_wv_r     <= cp_wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    cp_side_r   <= cp_side_nxt;
    cp_slot_r   <= cp_slot_nxt;
    cp_rk_r     <= cp_rk_nxt;
    cp_wk_r     <= cp_wk_nxt;
    out_byte_r  <= out_byte_nxt;
  end

  // An accepted transfer always starts with the commit of lane A.
  a_accept_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ncrf_pkg::ST_CMT_A)
    else $error("accepted transfer did not enter the commit stage");

  // The packet being sent still owns its queue entry.
  a_tx_slot_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ncrf_pkg::ST_RD && tx_phase_r == ncrf_pkg::TX_DATA) |-> pend_v_r[tx_slot_r])
    else $error("downlink data read from a free queue entry");

  // Store writes happen only inside a copy sweep.
  a_copy_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cp_wv_r |-> (state_r == ncrf_pkg::ST_CPY_A || state_r == ncrf_pkg::ST_CPY_B))
    else $error("store write outside a copy sweep");

  // A coded slot is held by both ends.
  a_coded_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (xored_r & ~(own_a_r & own_b_r)) == '0)
    else $error("coded slot without both packets");

endmodule

// ===== sv/ncrf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ncrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ncrf_rx.sv =====
// Uplink receiver lane: frame parser with its own staging RAM.
module ncrf_rx #(
  parameter int MAX_PACKET = ncrf_pkg::MAX_PACKET_DEF,
  localparam int KW = $clog2(MAX_PACKET),
  localparam int LW = $clog2(MAX_PACKET + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_i,
  input  ncrf_pkg::rx_ctl_t ctl,
  input  logic [LW-1:0]     eff_len,
  output ncrf_pkg::rx_evt_t evt,
  input  logic              cp_re,
  input  logic [KW-1:0]     cp_raddr,
  output logic [7:0]        cp_rdata
);

  ncrf_pkg::rx_phase_t phase_r, phase_nxt;
  logic [LW-1:0] idx_r, idx_nxt, idx_t;
  logic [2:0]    cnt_r, cnt_nxt, cnt_t;
  logic [7:0]    nb_r [3];
  logic [7:0]    nb_nxt [3];
  logic [7:0]    cur_r, cur_nxt;
  logic          stg_we;
  logic          got;
  logic [7:0]    vote;
  logic          id_hit;

  assign id_hit = (byte_i == ctl.id);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    nb_nxt    = nb_r;
    cur_nxt   = cur_r;
    stg_we    = 1'b0;
    evt       = '0;
    evt.num   = cur_r;
    idx_t     = LW'(idx_r + 1'b1);
    cnt_t     = cnt_r;
    got       = 1'b0;
    vote      = ncrf_pkg::BYTE_ZERO;
    unique case (phase_r)
      ncrf_pkg::RX_IDLE: begin
        if (id_hit) begin
          phase_nxt = ncrf_pkg::RX_ID;
          idx_nxt   = LW'(1);
          cnt_nxt   = 3'd1;
        end
      end
      ncrf_pkg::RX_ID: begin
        cnt_t = cnt_r + 3'(id_hit);
        if (idx_t >= LW'(ncrf_pkg::ID_REPEAT)) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          if (cnt_t == 3'(ncrf_pkg::ID_REPEAT)) begin
            phase_nxt = ncrf_pkg::RX_NUMBER;
          end else if (id_hit) begin
            // The failing third byte may itself open a new frame.
            phase_nxt = ncrf_pkg::RX_ID;
            idx_nxt   = LW'(1);
            cnt_nxt   = 3'd1;
          end else begin
            phase_nxt = ncrf_pkg::RX_IDLE;
          end
        end else begin
          idx_nxt = idx_t;
          cnt_nxt = cnt_t;
        end
      end
      ncrf_pkg::RX_NUMBER: begin
        if (idx_r < LW'(ncrf_pkg::NUM_REPEAT)) begin
          nb_nxt[idx_r[1:0]] = byte_i;
        end
        if (idx_t >= LW'(ncrf_pkg::NUM_REPEAT)) begin
          idx_nxt   = '0;
          phase_nxt = ncrf_pkg::RX_IDLE;
          got       = 1'b1;
          if (nb_nxt[0] == nb_nxt[1]) begin
            vote = nb_nxt[0];
          end else if (nb_nxt[1] == nb_nxt[2]) begin
            vote = nb_nxt[1];
          end else if (nb_nxt[2] == nb_nxt[0]) begin
            vote = nb_nxt[2];
          end else begin
            got = 1'b0;
          end
          if (got) begin
            if (vote == ncrf_pkg::BYTE_ZERO && !ctl.req_own && ctl.session_mode) begin
              phase_nxt = ncrf_pkg::RX_SESSION;
            end else if (vote != ncrf_pkg::BYTE_ZERO &&
                         (ctl.confirmed || !ctl.session_mode)) begin
              cur_nxt   = vote;
              phase_nxt = ncrf_pkg::RX_DATA;
            end
          end
        end else begin
          idx_nxt = idx_t;
        end
      end
      ncrf_pkg::RX_SESSION: begin
        cnt_t = cnt_r + 3'(byte_i == ctl.expected);
        if (idx_t >= LW'(ncrf_pkg::SESSION_LEN)) begin
          evt.set_req = (cnt_t == 3'(ncrf_pkg::SESSION_LEN));
          phase_nxt   = ncrf_pkg::RX_IDLE;
          idx_nxt     = '0;
          cnt_nxt     = '0;
        end else begin
          idx_nxt = idx_t;
          cnt_nxt = cnt_t;
        end
      end
      ncrf_pkg::RX_DATA: begin
        stg_we = 1'b1;
        if (idx_t >= eff_len) begin
          idx_nxt   = '0;
          phase_nxt = ncrf_pkg::RX_END;
        end else begin
          idx_nxt = idx_t;
        end
      end
      ncrf_pkg::RX_END: begin
        cnt_t = cnt_r + 3'(byte_i == ncrf_pkg::BYTE_ZERO);
        if (idx_t >= LW'(ncrf_pkg::TRAILER_LEN)) begin
          evt.commit = (cnt_t >= 3'(ncrf_pkg::TRAILER_MIN));
          phase_nxt  = ncrf_pkg::RX_IDLE;
          idx_nxt    = '0;
          cnt_nxt    = '0;
        end else begin
          idx_nxt = idx_t;
          cnt_nxt = cnt_t;
        end
      end
      default: begin
        phase_nxt = ncrf_pkg::RX_IDLE;
        idx_nxt   = '0;
        cnt_nxt   = '0;
      end
    endcase
    if (!step) begin
      evt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ncrf_pkg::RX_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      nb_r  <= nb_nxt;
      cur_r <= cur_nxt;
    end
  end

  ncrf_ram #(.WIDTH(8), .DEPTH(MAX_PACKET)) u_staging (
    .clk   (clk),
    .we    (step && stg_we),
    .waddr (idx_r[KW-1:0]),
    .wdata (byte_i),
    .re    (cp_re),
    .raddr (cp_raddr),
    .rdata (cp_rdata)
  );

endmodule

// ===== tb/sv/relay_downlink_checker.sv =====
// Checker of the relay framer: predicts each downlink byte and compares it with the block.
`timescale 1ns / 100ps
module relay_downlink_checker
  import ncrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ncrf_in_if         in_ch,
  ncrf_out_if        out_ch,
  ncrf_cfg_if        cfg_ch,
  output int         errors,
  output int         outstanding,
  output logic [7:0] session_byte
);

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int PMAX  = MAX_PACKET_DEF;

  localparam logic [4:0] F_REQ_A = 5'd1;
  localparam logic [4:0] F_REQ_B = 5'd2;
  localparam logic [4:0] F_CONF  = 5'd4;
  localparam logic [4:0] F_FULL  = 5'd8;
  localparam logic [4:0] F_OUT   = 5'd16;

  logic       mode, g_en;
  logic [7:0] g_len, id_a, id_b, rid;
  logic [8:0] plen;

  rx_phase_t  ph [2];
  int         idx [2];
  int         cnt [2];
  logic [7:0] nb [2][3];
  logic [7:0] cur [2];
  logic [7:0] stg [2][PMAX];
  logic [7:0] snum [2][SLOTS];
  logic [7:0] sxor [SLOTS];
  logic [7:0] spend [SLOTS];
  logic [7:0] st [2][SLOTS*PMAX];
  logic [7:0] sx [SLOTS*PMAX];
  logic [7:0] sp [SLOTS*PMAX];
  logic [4:0] flags;
  logic [7:0] exp_s;
  tx_phase_t  txp;
  int         conf, rep, dcnt, gcnt, tslot;

  logic [7:0] downlink_expect [$];
  int         mismatches;

  function automatic int eff_len();
    if (plen < PACKET_MIN) return PACKET_MIN;
    if (plen > PMAX) return PMAX;
    return int'(plen);
  endfunction

  function automatic int eff_guard();
    return (g_len < GUARD_MIN) ? GUARD_MIN : int'(g_len);
  endfunction

  function automatic int first_pend();
    for (int i = 0; i < SLOTS; i++)
      if (spend[i] != 0) return i;
    return -1;
  endfunction

  function automatic logic both_req();
    return (flags & (F_REQ_A | F_REQ_B)) == (F_REQ_A | F_REQ_B);
  endfunction

  function automatic void clear_model();
    mode = 1'b0; g_en = 1'b1; g_len = 8'd6;
    id_a = 8'd1; id_b = 8'd2; rid = 8'd3; plen = 9'd64;
    for (int s = 0; s < 2; s++) begin
      ph[s] = RX_IDLE; idx[s] = 0; cnt[s] = 0; cur[s] = 0;
      for (int k = 0; k < 3; k++) nb[s][k] = 0;
      for (int k = 0; k < PMAX; k++) stg[s][k] = 0;
      for (int k = 0; k < SLOTS; k++) snum[s][k] = 0;
      for (int k = 0; k < SLOTS*PMAX; k++) st[s][k] = 0;
    end
    for (int k = 0; k < SLOTS; k++) begin
      sxor[k] = 0; spend[k] = 0;
    end
    for (int k = 0; k < SLOTS*PMAX; k++) begin
      sx[k] = 0; sp[k] = 0;
    end
    flags = 0; exp_s = 8'd1; txp = TX_IDLE;
    conf = 0; rep = 0; dcnt = 0; gcnt = 0; tslot = 0;
  endfunction

  function automatic void queue_coded(int sl, logic [7:0] num);
    for (int i = 0; i < SLOTS; i++) begin
      if (spend[i] == 0) begin
        spend[i] = num;
        for (int k = 0; k < PMAX; k++) sp[i*PMAX+k] = sx[sl*PMAX+k];
        return;
      end
    end
  endfunction

  function automatic void commit_packet(int s);
    logic [7:0] num;
    int sl, len;
    num = cur[s];
    len = eff_len();
    if (num == 0 || num > SLOTS) return;
    sl = int'(num) - 1;
    if (snum[s][sl] == 0) begin
      snum[s][sl] = num;
      for (int k = 0; k < len; k++) st[s][sl*PMAX+k] = stg[s][k];
      if (snum[1-s][sl] == num) begin
        sxor[sl] = num;
        for (int k = 0; k < len; k++)
          sx[sl*PMAX+k] = stg[s][k] ^ st[1-s][sl*PMAX+k];
        queue_coded(sl, num);
      end
    end else if (sxor[sl] == num) begin
      queue_coded(sl, num);
    end
  endfunction

  function automatic void receive_byte(int s, logic [7:0] b);
    logic [7:0] id, n;
    logic [4:0] req;
    logic got;
    id = s ? id_b : id_a;
    req = s ? F_REQ_B : F_REQ_A;
    case (ph[s])
      RX_IDLE: begin
        if (b == id) begin
          ph[s] = RX_ID; idx[s] = 1; cnt[s] = 1;
        end
      end
      RX_ID: begin
        if (b == id) cnt[s]++;
        idx[s]++;
        if (idx[s] >= ID_REPEAT) begin
          got = (cnt[s] == ID_REPEAT);
          idx[s] = 0; cnt[s] = 0;
          if (got) ph[s] = RX_NUMBER;
          else begin
            // The byte that broke the ID run may itself start a new one.
            ph[s] = RX_IDLE;
            if (b == id) begin
              ph[s] = RX_ID; idx[s] = 1; cnt[s] = 1;
            end
          end
        end
      end
      RX_NUMBER: begin
        nb[s][idx[s]] = b;
        idx[s]++;
        if (idx[s] >= NUM_REPEAT) begin
          got = 1'b1; n = 0; idx[s] = 0;
          if (nb[s][0] == nb[s][1]) n = nb[s][0];
          else if (nb[s][1] == nb[s][2]) n = nb[s][1];
          else if (nb[s][2] == nb[s][0]) n = nb[s][2];
          else got = 1'b0;
          ph[s] = RX_IDLE;
          if (got) begin
            if (n == 0 && (flags & req) == 0 && mode) ph[s] = RX_SESSION;
            else if (n != 0 && ((flags & F_CONF) != 0 || !mode)) begin
              cur[s] = n; ph[s] = RX_DATA;
            end
          end
        end
      end
      RX_SESSION: begin
        if (b == exp_s) cnt[s]++;
        idx[s]++;
        if (idx[s] >= SESSION_LEN) begin
          if (cnt[s] == SESSION_LEN) flags = flags | req;
          ph[s] = RX_IDLE; idx[s] = 0; cnt[s] = 0;
        end
      end
      RX_DATA: begin
        stg[s][idx[s]] = b;
        idx[s]++;
        if (idx[s] >= eff_len()) begin
          idx[s] = 0; ph[s] = RX_END;
        end
      end
      RX_END: begin
        if (b == 0) cnt[s]++;
        idx[s]++;
        if (idx[s] >= TRAILER_LEN) begin
          if (cnt[s] >= TRAILER_MIN) commit_packet(s);
          ph[s] = RX_IDLE; idx[s] = 0; cnt[s] = 0;
        end
      end
      default: begin
        ph[s] = RX_IDLE; idx[s] = 0; cnt[s] = 0;
      end
    endcase
  endfunction

  function automatic logic transmit_byte(output logic [7:0] ob);
    int p, nc;
    logic sent;
    ob = 0;
    case (txp)
      TX_IDLE: begin
        if (!mode) begin
          p = first_pend();
          if (p >= 0) begin
            flags = flags | F_OUT; tslot = p; txp = TX_NODE_ID;
          end
        end else if (both_req()) txp = TX_CONFIRM;
        return 1'b0;
      end
      TX_CONFIRM: begin
        ob = (conf < 3) ? rid : BYTE_ZERO;
        conf++;
        if (conf >= CONFIRM_LEN) begin
          conf = 0; txp = TX_SESSION;
        end
        return 1'b1;
      end
      TX_SESSION: begin
        ob = exp_s;
        conf++;
        if (conf >= eff_len() - CONFIRM_LEN) begin
          flags = flags | F_CONF; conf = 0;
          p = first_pend();
          if (p >= 0) begin
            flags = flags | F_OUT; tslot = p; txp = TX_NODE_ID;
          end else txp = TX_CONFIRM;
        end
        return 1'b1;
      end
      TX_NODE_ID: begin
        ob = rid;
        rep++;
        if (rep >= ID_REPEAT) begin
          rep = 0; txp = TX_NUMBER;
        end
        return 1'b1;
      end
      TX_NUMBER: begin
        ob = spend[tslot];
        rep++;
        if (rep >= NUM_REPEAT) begin
          rep = 0; txp = TX_DATA;
        end
        return 1'b1;
      end
      TX_DATA: begin
        ob = sp[tslot*PMAX+dcnt];
        dcnt++;
        if (dcnt >= eff_len()) begin
          dcnt = 0; txp = TX_GUARD;
        end
        return 1'b1;
      end
      TX_GUARD: begin
        sent = 1'b0;
        if (g_en) begin
          ob = BYTE_ZERO; gcnt++; sent = 1'b1;
        end
        if (gcnt >= eff_guard() || !g_en) begin
          gcnt = 0;
          spend[tslot] = 0;
          p = first_pend();
          if (p >= 0) begin
            tslot = p; txp = TX_NODE_ID;
          end else txp = TX_CHECK;
          if ((flags & F_OUT) != 0 && (!mode || both_req())) begin
            nc = 0;
            for (int i = 0; i < SLOTS; i++)
              if (sxor[i] != 0) nc++;
            if (nc == SLOTS) begin
              // Every slot is coded: free-running sleeps, a session rolls over.
              if (!mode) txp = TX_SLEEP;
              else begin
                flags = (flags & ~(F_REQ_A | F_REQ_B | F_OUT)) | F_FULL;
                exp_s = (exp_s == BYTE_MAX) ? BYTE_ONE : exp_s + 8'd1;
              end
            end
          end
        end
        return sent;
      end
      TX_CHECK: begin
        if ((flags & F_FULL) != 0 && both_req()) begin
          flags = flags & ~(F_CONF | F_FULL);
          txp = TX_CONFIRM;
          for (int i = 0; i < SLOTS; i++) begin
            snum[0][i] = 0; snum[1][i] = 0; sxor[i] = 0; spend[i] = 0;
          end
          return 1'b0;
        end
        p = first_pend();
        if (p >= 0) begin
          tslot = p; txp = TX_NODE_ID;
        end
        return 1'b0;
      end
      TX_SLEEP: return 1'b0;
      default: begin
        txp = TX_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] r, logic [CFG_DATA_W-1:0] v);
    case (r)
      REG_SESSION_MODE:  mode = v[0];
      REG_GUARD_ENABLE:  g_en = v[0];
      REG_GUARD_LENGTH:  g_len = v[7:0];
      REG_NODE_A_ID:     id_a = v[7:0];
      REG_NODE_B_ID:     id_b = v[7:0];
      REG_RELAY_ID:      rid = v[7:0];
      REG_PACKET_LENGTH: plen = v;
      default: ;
    endcase
  endfunction

  initial begin
    errors = 0;
    mismatches = 0;
    outstanding = 0;
    clear_model();
    session_byte = exp_s;
  end

  always @(posedge clk) begin
    logic [7:0] ob;
    logic [7:0] want;
    if (!rst_n) begin
      clear_model();
      downlink_expect.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (downlink_expect.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("unexpected downlink byte %02h at %0t", out_ch.tx_byte, $realtime);
          mismatches++;
        end else begin
          want = downlink_expect.pop_front();
          if (out_ch.tx_byte !== want) begin
            errors++;
            if (mismatches < 10)
              $display("downlink byte mismatch at %0t: expected %02h, got %02h",
                       $realtime, want, out_ch.tx_byte);
            mismatches++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        receive_byte(0, in_ch.byte_a);
        receive_byte(1, in_ch.byte_b);
        if (transmit_byte(ob)) downlink_expect.push_back(ob);
      end
    end
    outstanding = downlink_expect.size();
    session_byte = exp_s;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the relay framer: stimulus, back pressure and the verdict.
`timescale 1ns / 100ps
module tb;
  import ncrf_pkg::*;

  // Kinds of uplink frame the stimulus can build.
  localparam int FR_GOOD      = 0;
  localparam int FR_BAD_ID    = 1;
  localparam int FR_VOTE_ONE  = 2;
  localparam int FR_VOTE_NONE = 3;
  localparam int FR_TRAIL_ONE = 4;
  localparam int FR_TRAIL_TWO = 5;

  // Cycles to let pass after the last result, covering two full packet copies.
  localparam int DRAIN_CYCLES = 600;

  logic clk;
  logic rst_n;

  ncrf_in_if  in_if ();
  ncrf_out_if out_if ();
  ncrf_cfg_if cfg_if ();

  int         err_cnt;
  int         waiting;
  logic [7:0] sess_val;

  // Shadow copies of the registers that shape the uplink frames.
  logic [7:0] id_a, id_b;
  logic [8:0] plen;

  logic [7:0] qa [$];
  logic [7:0] qb [$];

  logic hold_req;
  int   stall_left;

  network_coding_relay_framer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  relay_downlink_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_ch       (cfg_if),
    .errors       (err_cnt),
    .outstanding  (waiting),
    .session_byte (sess_val)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #20000000;
    $display("tb failed");
    $finish;
  end

  // Downlink receiver. It mostly accepts, sometimes stalls briefly and now and
  // then for a long stretch. A hold request from the stimulus forces one very
  // long stall so that the output register fills and the input backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_req) stall_left = 400;
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_if.ready <= 1'b0;
      end
    end
  end

  function automatic int eff_len();
    if (plen < PACKET_MIN) return PACKET_MIN;
    if (plen > MAX_PACKET_DEF) return MAX_PACKET_DEF;
    return int'(plen);
  endfunction

  // Sender gaps: mostly none, some short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put(int side, logic [7:0] v);
    if (side != 0) qb.push_back(v);
    else qa.push_back(v);
  endfunction

  // Register write; the shadow copies follow the transfer.
  task automatic write_reg(cfg_reg_t r, int v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= v[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (r)
      REG_NODE_A_ID:     id_a = v[7:0];
      REG_NODE_B_ID:     id_b = v[7:0];
      REG_PACKET_LENGTH: plen = v[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One input transfer; valid stays high across back-to-back items.
  task automatic push_item(logic [7:0] a, logic [7:0] b);
    int g;
    in_if.valid  <= 1'b1;
    in_if.byte_a <= a;
    in_if.byte_b <= b;
    do @(posedge clk); while (!in_if.ready);
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Streams both byte queues out in lockstep, padding the shorter with zeros.
  task automatic pump();
    logic [7:0] a, b;
    while (qa.size() != 0 || qb.size() != 0) begin
      a = (qa.size() != 0) ? qa.pop_front() : 8'h00;
      b = (qb.size() != 0) ? qb.pop_front() : 8'h00;
      push_item(a, b);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic add_frame(int side, logic [7:0] num, int kind);
    logic [7:0] id, x;
    int pos, len;
    id = side ? id_b : id_a;
    len = eff_len();
    // A broken ID run whose last byte starts a fresh run.
    if (kind == FR_BAD_ID) begin
      put(side, id);
      put(side, id + 8'd1);
    end
    repeat (3) put(side, id);
    if (kind == FR_VOTE_ONE) begin
      pos = $urandom_range(0, 2);
      x = num ^ 8'($urandom_range(1, 255));
      for (int k = 0; k < 3; k++) put(side, (k == pos) ? x : num);
    end else if (kind == FR_VOTE_NONE) begin
      put(side, num);
      put(side, num + 8'd1);
      put(side, num + 8'd2);
    end else begin
      repeat (3) put(side, num);
    end
    repeat (len) put(side, 8'($urandom_range(0, 255)));
    pos = $urandom_range(0, 5);
    for (int k = 0; k < TRAILER_LEN; k++) begin
      if ((kind == FR_TRAIL_ONE || kind == FR_TRAIL_TWO) && k == pos)
        put(side, 8'($urandom_range(1, 255)));
      else if (kind == FR_TRAIL_TWO && k == (pos + 3) % TRAILER_LEN)
        put(side, 8'($urandom_range(1, 255)));
      else
        put(side, 8'h00);
    end
  endtask

  // Session request: a zero packet number followed by six session bytes.
  task automatic add_session(int side, logic good);
    logic [7:0] id;
    int bad;
    id = side ? id_b : id_a;
    bad = good ? -1 : $urandom_range(0, 5);
    repeat (3) put(side, id);
    repeat (3) put(side, 8'h00);
    for (int k = 0; k < SESSION_LEN; k++)
      put(side, (k == bad) ? ~sess_val : sess_val);
  endtask

  function automatic logic [7:0] pick_num();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(1, SLOT_COUNT_DEF));
    if (r < 90) return 8'h00;
    return 8'($urandom_range(SLOT_COUNT_DEF + 1, 255));
  endfunction

  function automatic int pick_kind();
    return ($urandom_range(0, 9) != 0) ? FR_GOOD : $urandom_range(FR_BAD_ID, FR_TRAIL_TWO);
  endfunction

  // One random action: mostly matched frame pairs, then session requests,
  // single-sided frames and plain noise.
  task automatic random_action();
    int r;
    logic [7:0] n;
    r = $urandom_range(0, 99);
    n = pick_num();
    if (r < 65) begin
      add_frame(0, n, pick_kind());
      add_frame(1, n, pick_kind());
    end else if (r < 80) begin
      add_session(0, $urandom_range(0, 4) != 0);
      add_session(1, $urandom_range(0, 4) != 0);
    end else if (r < 90) begin
      add_frame($urandom_range(0, 1), n, pick_kind());
    end else begin
      repeat ($urandom_range(1, 8)) put(0, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 8)) put(1, 8'($urandom_range(0, 255)));
    end
    pump();
  endtask

  // Codes every slot once, with random actions mixed in, then asks for a new session.
  task automatic fill_slots();
    for (int s = 1; s <= SLOT_COUNT_DEF; s++) begin
      add_frame(0, 8'(s), FR_GOOD);
      add_frame(1, 8'(s), FR_GOOD);
      pump();
      if ($urandom_range(0, 3) == 0) random_action();
    end
    add_session(0, 1'b1);
    add_session(1, 1'b1);
    pump();
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Idle point for register writes: all results in, copies finished.
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.byte_a = 8'h00;
    in_if.byte_b = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SESSION_MODE;
    cfg_if.data = '0;
    id_a = 8'd1;
    id_b = 8'd2;
    plen = 9'd64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Session mode at the largest packet length with extreme IDs and guard.
    write_reg(REG_SESSION_MODE, 1);
    write_reg(REG_GUARD_ENABLE, 1);
    write_reg(REG_GUARD_LENGTH, 255);
    write_reg(REG_NODE_A_ID, 255);
    write_reg(REG_NODE_B_ID, 1);
    write_reg(REG_RELAY_ID, 255);
    write_reg(REG_PACKET_LENGTH, 511);
    add_session(0, 1'b1);
    add_session(1, 1'b1);
    pump();
    add_frame(0, 8'd1, FR_GOOD);
    add_frame(1, 8'd1, FR_GOOD);
    pump();
    settle();

    // Directed special cases at a moderate length, guard below the minimum.
    write_reg(REG_PACKET_LENGTH, 64);
    write_reg(REG_GUARD_LENGTH, 0);
    write_reg(REG_NODE_A_ID, 1);
    write_reg(REG_NODE_B_ID, 2);
    write_reg(REG_RELAY_ID, 3);
    add_frame(0, 8'd2, FR_BAD_ID);
    add_frame(1, 8'd2, FR_GOOD);
    pump();
    add_frame(0, 8'd3, FR_VOTE_ONE);
    add_frame(1, 8'd3, FR_VOTE_ONE);
    add_frame(0, 8'd4, FR_VOTE_NONE);
    pump();
    add_frame(0, 8'd5, FR_TRAIL_ONE);
    add_frame(1, 8'd5, FR_GOOD);
    add_frame(0, 8'd6, FR_TRAIL_TWO);
    add_frame(1, 8'd6, FR_GOOD);
    pump();
    add_frame(0, 8'd200, FR_GOOD);
    add_frame(1, 8'd200, FR_GOOD);
    add_session(0, 1'b0);
    pump();
    // The same coded number again is queued anew, once for each end's commit.
    add_frame(0, 8'd5, FR_GOOD);
    add_frame(1, 8'd5, FR_GOOD);
    pump();

    // Long receiver hold while the sender keeps offering items.
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (6) random_action();
    // Sender pauses until every expected byte has come out.
    wait_drained();
    repeat (6) random_action();
    settle();

    // Short packets, no guard: code every slot and roll the session over.
    write_reg(REG_PACKET_LENGTH, 20);
    write_reg(REG_GUARD_ENABLE, 0);
    fill_slots();
    repeat (8) random_action();
    settle();

    // Length below the minimum saturates; guard back on at its minimum.
    write_reg(REG_PACKET_LENGTH, 0);
    write_reg(REG_GUARD_ENABLE, 1);
    write_reg(REG_GUARD_LENGTH, 6);
    fill_slots();
    repeat (10) random_action();
    fill_slots();
    repeat (10) random_action();
    settle();

    // Free-running relaying to the end, until every slot is coded and it sleeps.
    write_reg(REG_SESSION_MODE, 0);
    repeat (15) random_action();
    fill_slots();
    repeat (5) random_action();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && waiting == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
